/* rtl/rlpl_pkg.sv */
`timescale 1ns / 1ps

package rlpl_pkg;

    // request kinds carried on s_axis_tuser
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // request tdata layout, lowest bit first
    localparam int SLOT_LSB   = 0;
    localparam int SV_BIT     = 4;
    localparam int PFX_LSB    = 5;
    localparam int MSK_LSB    = 37;
    localparam int GW_LSB     = 69;
    localparam int PORT_LSB   = 101;
    localparam int ADDR_LSB   = 105;
    localparam int S_TDATA_W  = 144;

    // result tdata layout, lowest bit first
    localparam int HIT_LSB    = 0;
    localparam int NH_LSB     = 4;
    localparam int OPORT_LSB  = 36;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic take;      // latch request, clear scan state
        logic scan_rd;   // read slot at scan counter, advance
        logic out_load;  // load result register
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last; // scan counter at last slot
    } dp_status_t;

endpackage

/* rtl/rlpl_ctrl.sv */
`timescale 1ns / 1ps

module rlpl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output rlpl_pkg::dp_cmd_t    cmd,
    input  rlpl_pkg::dp_status_t status
);
    import rlpl_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.take = 1'b1;
                    state_next = (s_axis_tuser == CMD_LOOKUP) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_FLUSH;
                end
            end
            // last read is compared in this cycle
            ST_FLUSH: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_axis_tready) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid_reg || m_axis_tready))
        else $error("result loaded over a pending result");

    a_lookup_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_LOOKUP)
            |=> (state_reg == ST_SCAN))
        else $error("lookup did not start a scan");

    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && status.scan_last) |=> (state_reg == ST_FLUSH))
        else $error("scan overran the last slot");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

endmodule

/* rtl/rlpl_dp.sv */
`timescale 1ns / 1ps

module rlpl_dp #(
    parameter int ENTRIES   = 16,
    parameter int PORT_BITS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [rlpl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tuser,
    output logic [rlpl_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tuser,
    input  rlpl_pkg::dp_cmd_t               cmd,
    output rlpl_pkg::dp_status_t            status
);
    import rlpl_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ENT_W = 96 + PORT_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [ENT_W-1:0] mem [0:ENTRIES-1];
    logic [ENTRIES-1:0] valid_reg;

    logic [3:0]           wr_slot;
    logic [IDX_W-1:0]     wr_idx;
    logic                 wr_en;
    logic [ENT_W-1:0]     wr_data;

    logic [31:0]          addr_reg;
    logic [IDX_W-1:0]     cnt_reg;
    logic [ENT_W-1:0]     rd_data_reg;
    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 pipe_reg;

    logic [31:0]          rd_pfx, rd_msk, rd_gw;
    logic [PORT_BITS-1:0] rd_port;
    logic                 better;

    logic                 hit_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [31:0]          best_mask_reg;
    logic [31:0]          best_gw_reg;
    logic [PORT_BITS-1:0] best_port_reg;

    logic                 out_found_reg;
    logic [3:0]           out_slot_reg;
    logic [31:0]          out_nh_reg;
    logic [3:0]           out_port_reg;

    assign wr_slot = s_axis_tdata[SLOT_LSB +: 4];
    assign wr_idx  = IDX_W'(wr_slot);
    assign wr_en   = cmd.take && (s_axis_tuser == CMD_WRITE) && (32'(wr_slot) < ENTRIES);
    assign wr_data = {PORT_BITS'(s_axis_tdata[PORT_LSB +: 4]),
                      s_axis_tdata[GW_LSB +: 32],
                      s_axis_tdata[MSK_LSB +: 32],
                      s_axis_tdata[PFX_LSB +: 32]};

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (cmd.scan_rd) begin
            rd_data_reg <= mem[cnt_reg];
        end
    end

    assign rd_pfx  = rd_data_reg[31:0];
    assign rd_msk  = rd_data_reg[63:32];
    assign rd_gw   = rd_data_reg[95:64];
    assign rd_port = rd_data_reg[ENT_W-1:96];

    // strictly longer mask replaces, so the lowest slot keeps a tie
    assign better = pipe_reg && rd_vld_reg && ((addr_reg & rd_msk) == rd_pfx)
                    && (!hit_reg || (rd_msk > best_mask_reg));

    assign status.scan_last = (cnt_reg == LAST_IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            pipe_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_idx] <= s_axis_tdata[SV_BIT];
            end
            pipe_reg <= cmd.scan_rd;
            if (cmd.take) begin
                hit_reg <= 1'b0;
            end else if (better) begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            addr_reg <= s_axis_tdata[ADDR_LSB +: 32];
            cnt_reg  <= '0;
        end else if (cmd.scan_rd) begin
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd.scan_rd) begin
            rd_vld_reg <= valid_reg[cnt_reg];
            rd_idx_reg <= cnt_reg;
        end
        if (better) begin
            best_idx_reg  <= rd_idx_reg;
            best_mask_reg <= rd_msk;
            best_gw_reg   <= rd_gw;
            best_port_reg <= rd_port;
        end
        if (cmd.out_load) begin
            out_found_reg <= hit_reg;
            out_slot_reg  <= hit_reg ? 4'(best_idx_reg) : 4'd0;
            out_nh_reg    <= hit_reg ? best_gw_reg : 32'd0;
            out_port_reg  <= hit_reg ? 4'(best_port_reg) : 4'd0;
        end
    end

    assign m_axis_tuser = out_found_reg;
    assign m_axis_tdata = {out_port_reg, out_nh_reg, out_slot_reg};

    a_pipe_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_rd |=> pipe_reg)
        else $error("read not followed by compare");

    a_hit_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |=> !hit_reg)
        else $error("best match survived a new request");

    a_no_compare_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> !pipe_reg)
        else $error("request taken while a compare is in flight");

endmodule

/* rtl/route_longest_prefix_lookup.sv */
`timescale 1ns / 1ps
// Write: once the request is taken the block moves to the done state, loads the result register
// and returns to idle. Lookup: once the request is taken the block scans the table, flushes the
// last compare and loads the result in the done state. A new request is taken only in idle, so
// requests never overlap; the single comparator scans one slot per cycle through the one read port.
// Reset (aresetn low, synchronous) clears all valid bits and the handshake state;
// table contents stay undefined until written, with no clearing pass.

module route_longest_prefix_lookup #(
    parameter int ENTRIES   = 16,
    parameter int PORT_BITS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot[3:0], slot_valid[4], prefix[36:5], prefix_mask[68:37],
    // gateway[100:69], port[104:101], lookup_address[136:105], zero pad
    input  logic [rlpl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // cmd[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // hit_slot[3:0], next_hop[35:4], out_port[39:36]
    output logic [rlpl_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // found[0]
    output logic                            m_axis_tuser
);
    import rlpl_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    rlpl_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (dp_cmd),
        .status        (dp_status)
    );

    rlpl_dp #(
        .ENTRIES   (ENTRIES),
        .PORT_BITS (PORT_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cmd          (dp_cmd),
        .status       (dp_status)
    );

endmodule

/* verif/route_lookup_checker.sv */
`timescale 1ns / 1ps

module route_lookup_checker #(
    parameter int ENTRIES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [rlpl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [rlpl_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                            m_axis_tuser,
    output int                              error_count,
    output int                              outstanding
);
    import rlpl_pkg::*;

    typedef struct packed {
        logic        found;
        logic [3:0]  hit_slot;
        logic [31:0] next_hop;
        logic [3:0]  out_port;
    } route_t;

    bit [31:0] tbl_prefix [ENTRIES];
    bit [31:0] tbl_mask   [ENTRIES];
    bit [31:0] tbl_gw     [ENTRIES];
    bit [3:0]  tbl_port   [ENTRIES];
    bit        tbl_valid  [ENTRIES];

    route_t expected_routes [$];
    int     errs = 0;

    initial begin
        error_count = 0;
        outstanding = 0;
    end

    // longest mask wins, lowest slot on equal masks
    function automatic route_t lookup_route(input logic [31:0] dest);
        route_t     r;
        logic [31:0] best_mask;
        r = '0;
        best_mask = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && ((dest & tbl_mask[i]) == tbl_prefix[i]) &&
                (!r.found || tbl_mask[i] > best_mask)) begin
                r.found    = 1'b1;
                r.hit_slot = i[3:0];
                r.next_hop = tbl_gw[i];
                r.out_port = tbl_port[i];
                best_mask  = tbl_mask[i];
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        route_t     got;
        route_t     want;
        logic [3:0] slot;
        if (!aresetn) begin
            expected_routes.delete();
            for (int i = 0; i < ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
            end
            outstanding <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.found    = m_axis_tuser;
                got.hit_slot = m_axis_tdata[HIT_LSB +: 4];
                got.next_hop = m_axis_tdata[NH_LSB +: 32];
                got.out_port = m_axis_tdata[OPORT_LSB +: 4];
                if (expected_routes.size() == 0) begin
                    if (errs < 10) begin
                        $display("%0t: unexpected result found=%0d slot=%0d next_hop=%h port=%0d",
                                 $realtime, got.found, got.hit_slot, got.next_hop,
                                 got.out_port);
                    end
                    errs++;
                end else begin
                    want = expected_routes.pop_front();
                    if (got.found !== want.found || got.hit_slot !== want.hit_slot ||
                        got.next_hop !== want.next_hop || got.out_port !== want.out_port) begin
                        if (errs < 10) begin
                            $display("%0t: result mismatch: expected found=%0d slot=%0d next_hop=%h port=%0d",
                                     $realtime, want.found, want.hit_slot, want.next_hop,
                                     want.out_port);
                            $display("%0t:                  got      found=%0d slot=%0d next_hop=%h port=%0d",
                                     $realtime, got.found, got.hit_slot, got.next_hop,
                                     got.out_port);
                        end
                        errs++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == CMD_WRITE) begin
                    slot = s_axis_tdata[SLOT_LSB +: 4];
                    if (slot < ENTRIES) begin
                        tbl_prefix[slot] = s_axis_tdata[PFX_LSB +: 32];
                        tbl_mask[slot]   = s_axis_tdata[MSK_LSB +: 32];
                        tbl_gw[slot]     = s_axis_tdata[GW_LSB +: 32];
                        tbl_port[slot]   = s_axis_tdata[PORT_LSB +: 4];
                        tbl_valid[slot]  = s_axis_tdata[SV_BIT];
                    end
                    // a write answers with an all-zero result
                    expected_routes.push_back('0);
                end else begin
                    expected_routes.push_back(lookup_route(s_axis_tdata[ADDR_LSB +: 32]));
                end
            end
            outstanding <= expected_routes.size();
        end
        error_count <= errs;
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;
    import rlpl_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int RANDOM_REQS = 1850;
    localparam int QUIET_TAIL  = 200;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    wire                   s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready;
    wire  [M_TDATA_W-1:0]  m_axis_tdata;
    wire                   m_axis_tuser;

    int error_count;
    int outstanding;
    bit quiet = 1'b0;
    int rx_stall = 0;

    // routes written so far, used to aim lookups at stored prefixes
    bit [31:0] net_pfx [ENTRIES];
    bit [31:0] net_msk [ENTRIES];

    route_longest_prefix_lookup #(
        .ENTRIES   (ENTRIES),
        .PORT_BITS (4)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    route_lookup_checker #(
        .ENTRIES (ENTRIES)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (error_count),
        .outstanding   (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side back-pressure in short bursts
    always @(posedge aclk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            rx_stall      <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // hold the request until the block takes it
    task automatic send_req(input logic cmd, input logic [S_TDATA_W-1:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_route(input logic [3:0] slot, input logic vld,
                               input logic [31:0] pfx, input logic [31:0] msk,
                               input logic [31:0] gw, input logic [3:0] port);
        logic [S_TDATA_W-1:0] data;
        net_pfx[slot] = pfx;
        net_msk[slot] = msk;
        data = '0;
        data[SLOT_LSB +: 4]  = slot;
        data[SV_BIT]         = vld;
        data[PFX_LSB +: 32]  = pfx;
        data[MSK_LSB +: 32]  = msk;
        data[GW_LSB +: 32]   = gw;
        data[PORT_LSB +: 4]  = port;
        data[ADDR_LSB +: 32] = $urandom();
        send_req(CMD_WRITE, data);
    endtask

    task automatic lookup_dest(input logic [31:0] dest);
        logic [S_TDATA_W-1:0] data;
        logic [127:0]         noise;
        noise = {$urandom(), $urandom(), $urandom(), $urandom()};
        data = '0;
        data[ADDR_LSB-1:0]   = noise[ADDR_LSB-1:0];
        data[ADDR_LSB +: 32] = dest;
        send_req(CMD_LOOKUP, data);
    endtask

    function automatic logic [31:0] contig_mask(input int len);
        if (len == 0) begin
            return '0;
        end
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    task automatic random_write();
        int          pick;
        int          other;
        logic [31:0] pfx;
        logic [31:0] msk;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            // copy another slot's route to force ties
            other = $urandom_range(0, ENTRIES - 1);
            msk = net_msk[other];
            pfx = net_pfx[other] & msk;
        end else begin
            if (pick < 75) begin
                msk = contig_mask($urandom_range(0, 32));
            end else if (pick < 85) begin
                msk = $urandom();
            end else if (pick < 92) begin
                msk = '1;
            end else begin
                msk = '0;
            end
            pfx = $urandom();
            if ($urandom_range(0, 9) != 0) begin
                pfx = pfx & msk;
            end
        end
        write_route(4'($urandom_range(0, ENTRIES - 1)), $urandom_range(0, 7) != 0,
                    pfx, msk, $urandom(), 4'($urandom_range(0, 15)));
    endtask

    task automatic random_lookup();
        int          s;
        logic [31:0] dest;
        if ($urandom_range(0, 9) < 7) begin
            s = $urandom_range(0, ENTRIES - 1);
            dest = (net_pfx[s] & net_msk[s]) | ($urandom() & ~net_msk[s]);
        end else begin
            dest = $urandom();
        end
        lookup_dest(dest);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_WRITE;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table
        lookup_dest(32'hFFFF_FFFF);
        sender_gap();
        // default route, then a host route
        write_route(4'd0, 1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF, 4'hF);
        lookup_dest(32'h0);
        sender_gap();
        write_route(4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'h0);
        lookup_dest(32'hFFFF_FFFF);
        sender_gap();
        // equal masks: lower slot wins
        write_route(4'd5, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'h1234_5678, 4'd5);
        write_route(4'd3, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'h8765_4321, 4'd3);
        lookup_dest(32'h0A01_0203);
        sender_gap();
        // longer mask in a higher slot beats the /8
        write_route(4'd9, 1'b1, 32'h0A01_0000, 32'hFFFF_0000, 32'hCAFE_0009, 4'd9);
        lookup_dest(32'h0A01_0203);
        // prefix with bits outside its mask never matches
        write_route(4'd7, 1'b1, 32'h0A00_00FF, 32'hFFFF_0000, 32'hA5A5_A5A5, 4'd7);
        lookup_dest(32'h0A00_00FF);
        sender_gap();
        // non-contiguous mask
        write_route(4'd8, 1'b1, 32'h0000_000F, 32'h8000_000F, 32'h5A5A_5A5A, 4'd8);
        lookup_dest(32'h0000_000F);
        lookup_dest(32'h0A00_000F);
        // invalidate the host route, then the default route
        write_route(4'd15, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 4'd1);
        lookup_dest(32'hFFFF_FFFF);
        sender_gap();
        write_route(4'd0, 1'b0, 32'h0, 32'h0, 32'h0, 4'd0);
        lookup_dest(32'h1234_5678);
        sender_gap();

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == RANDOM_REQS / 2) begin
                drain();
            end
            if (n == RANDOM_REQS - QUIET_TAIL) begin
                quiet <= 1'b1;
            end
            if ($urandom_range(0, 99) < 35) begin
                random_write();
            end else begin
                random_lookup();
            end
            sender_gap();
        end

        drain();
        repeat (ENTRIES + 8) @(posedge aclk);
        if (error_count == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
